// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while rst_n is low.
`define VBAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and muted while rst_n is low.
`define VBAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/vbad_pkg.sv =====
// Shared constants and types of the volume block average downsampler.
package vbad_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_OUT_SIDE_DEF = 64;
  localparam int MAX_FACTOR_DEF   = 8;
  localparam int SAMPLE_BITS_DEF  = 32;

  // Configuration registers.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int FACTOR_W    = 4;
  localparam int OUT_SIZE_W  = 7;

  localparam logic [CFG_IDX_W-1:0]  CFG_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_OUT_SIZE = 2'd1;
  localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 4'd1;
  localparam logic [OUT_SIZE_W-1:0] OUT_SIZE_RST = 7'd64;

  // Depth of the queue between the front and back parts (power of two).
  localparam int QDEPTH = 4;

  // Classification of one voxel inside its block.
  typedef struct packed {
    logic vol_end;
    logic last;
    logic first;
  } blk_flags_t;

  localparam int FLAGS_W = $bits(blk_flags_t);

  // Back part to divider.
  typedef struct packed {
    logic start;
    logic take;
  } div_ctl_t;

  // Divider to back part.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Back part sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_DIV
  } bk_state_t;

  // Back part events observed by the top level checks.
  typedef struct packed {
    logic out_load;
    logic div_start;
    logic div_busy;
  } bk_status_t;

endpackage

// ===== rtl/vbad_front.sv =====
// Front part: configuration registers, voxel position tracking and block classification.
module vbad_front #(
  parameter int MAX_OUT_SIDE = vbad_pkg::MAX_OUT_SIDE_DEF,
  parameter int MAX_FACTOR   = vbad_pkg::MAX_FACTOR_DEF,
  parameter int SAMPLE_BITS  = vbad_pkg::SAMPLE_BITS_DEF,
  localparam int CUBE_W = $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR + 1),
  localparam int ADDR_W = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE * MAX_OUT_SIDE) : 1
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_we,
  input  logic [vbad_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [vbad_pkg::CFG_DATA_W-1:0]                  cfg_wdata,
  input  logic                                             push,
  input  logic signed [SAMPLE_BITS-1:0]                    sample,
  output logic [SAMPLE_BITS+ADDR_W+vbad_pkg::FLAGS_W-1:0]  item,
  output logic [CUBE_W-1:0]                                cube
);

  localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int BLK_W  = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int NW     = $clog2(MAX_OUT_SIDE + 1);
  localparam int SQ_W   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int PROD_W = BLK_W + NW + 1;

  logic [vbad_pkg::FACTOR_W-1:0]   factor_r, factor_nxt;
  logic [vbad_pkg::OUT_SIZE_W-1:0] out_size_r, out_size_nxt;
  logic                            restart;

  logic [FW-1:0]     eff_f;
  logic [NW-1:0]     eff_n;
  logic [SUB_W-1:0]  f_m1;
  logic [BLK_W-1:0]  n_m1;
  logic [SQ_W-1:0]   sq_r;
  logic [CUBE_W-1:0] cube_r;

  logic [SUB_W-1:0] sub_o_r, sub_m_r, sub_i_r, sub_o_nxt, sub_m_nxt, sub_i_nxt;
  logic [BLK_W-1:0] blk_o_r, blk_m_r, blk_i_r, blk_o_nxt, blk_m_nxt, blk_i_nxt;

  logic se_o, se_m, se_i, be_o, be_m, be_i;
  logic carry_m, carry_o;
  logic [PROD_W-1:0] cell_full;
  logic [ADDR_W-1:0] cell_addr;
  vbad_pkg::blk_flags_t flags;

  // Register writes; a write to a known index restarts the volume.
  always_comb begin
    factor_nxt   = factor_r;
    out_size_nxt = out_size_r;
    restart      = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        vbad_pkg::CFG_FACTOR: begin
          factor_nxt = cfg_wdata[vbad_pkg::FACTOR_W-1:0];
          restart    = 1'b1;
        end
        vbad_pkg::CFG_OUT_SIZE: begin
          out_size_nxt = cfg_wdata[vbad_pkg::OUT_SIZE_W-1:0];
          restart      = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r   <= vbad_pkg::FACTOR_RST;
      out_size_r <= vbad_pkg::OUT_SIZE_RST;
    end else begin
      factor_r   <= factor_nxt;
      out_size_r <= out_size_nxt;
    end
  end

  // Effective factor and side, clamped into the supported range.
  always_comb begin
    if (factor_r == '0) begin
      eff_f = FW'(1);
    end else if (int'(factor_r) > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_r);
    end
    if (out_size_r == '0) begin
      eff_n = NW'(1);
    end else if (int'(out_size_r) > MAX_OUT_SIDE) begin
      eff_n = NW'(MAX_OUT_SIDE);
    end else begin
      eff_n = NW'(out_size_r);
    end
  end

  assign f_m1 = SUB_W'(eff_f - FW'(1));
  assign n_m1 = BLK_W'(eff_n - NW'(1));

  // Block volume factor cubed, one multiplication per register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r   <= SQ_W'(1);
      cube_r <= CUBE_W'(1);
    end else begin
      sq_r   <= SQ_W'(eff_f) * SQ_W'(eff_f);
      cube_r <= CUBE_W'(sq_r) * CUBE_W'(eff_f);
    end
  end

  assign cube = cube_r;

  // End-of-block and end-of-side detection per axis.
  assign se_i = (sub_i_r == f_m1);
  assign se_m = (sub_m_r == f_m1);
  assign se_o = (sub_o_r == f_m1);
  assign be_i = (blk_i_r == n_m1);
  assign be_m = (blk_m_r == n_m1);
  assign be_o = (blk_o_r == n_m1);

  assign carry_m = se_i && be_i;
  assign carry_o = carry_m && se_m && be_m;

  // Position advance: the inner axis steps on every voxel, the others on carry.
  always_comb begin
    sub_i_nxt = sub_i_r;
    blk_i_nxt = blk_i_r;
    sub_m_nxt = sub_m_r;
    blk_m_nxt = blk_m_r;
    sub_o_nxt = sub_o_r;
    blk_o_nxt = blk_o_r;
    if (push) begin
      if (se_i) begin
        sub_i_nxt = '0;
        blk_i_nxt = be_i ? '0 : blk_i_r + BLK_W'(1);
      end else begin
        sub_i_nxt = sub_i_r + SUB_W'(1);
      end
      if (carry_m) begin
        if (se_m) begin
          sub_m_nxt = '0;
          blk_m_nxt = be_m ? '0 : blk_m_r + BLK_W'(1);
        end else begin
          sub_m_nxt = sub_m_r + SUB_W'(1);
        end
      end
      if (carry_o) begin
        if (se_o) begin
          sub_o_nxt = '0;
          blk_o_nxt = be_o ? '0 : blk_o_r + BLK_W'(1);
        end else begin
          sub_o_nxt = sub_o_r + SUB_W'(1);
        end
      end
    end
    if (restart) begin
      sub_i_nxt = '0;
      blk_i_nxt = '0;
      sub_m_nxt = '0;
      blk_m_nxt = '0;
      sub_o_nxt = '0;
      blk_o_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_i_r <= '0;
      blk_i_r <= '0;
      sub_m_r <= '0;
      blk_m_r <= '0;
      sub_o_r <= '0;
      blk_o_r <= '0;
    end else begin
      sub_i_r <= sub_i_nxt;
      blk_i_r <= blk_i_nxt;
      sub_m_r <= sub_m_nxt;
      blk_m_r <= blk_m_nxt;
      sub_o_r <= sub_o_nxt;
      blk_o_r <= blk_o_nxt;
    end
  end

  // Accumulator address within the plane and block classification.
  assign cell_full = PROD_W'(blk_m_r) * PROD_W'(eff_n) + PROD_W'(blk_i_r);
  assign cell_addr = cell_full[ADDR_W-1:0];

  assign flags.first   = (sub_i_r == '0) && (sub_m_r == '0) && (sub_o_r == '0);
  assign flags.last    = se_i && se_m && se_o;
  assign flags.vol_end = flags.last && be_i && be_m && be_o;

  assign item = {sample, cell_addr, flags};

endmodule

// ===== rtl/vbad_fifo.sv =====
// Short request queue between the front and back parts.
module vbad_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (vbad_pkg::QDEPTH > 1) ? $clog2(vbad_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(vbad_pkg::QDEPTH + 1);

  logic [WIDTH-1:0] slot_r [vbad_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(vbad_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/vbad_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module vbad_div #(
  parameter int ACC_W       = 42,
  parameter int CUBE_W      = 10,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vbad_pkg::div_ctl_t            ctl,
  input  logic signed [ACC_W-1:0]       dividend,
  input  logic [CUBE_W-1:0]             divisor,
  output vbad_pkg::div_sts_t            sts,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  localparam int CW = $clog2(ACC_W + 1);

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CUBE_W:0]   rem_r, rem_nxt;
  logic [ACC_W-1:0]  quo_r, quo_nxt;
  logic [CUBE_W-1:0] dsr_r;
  logic              neg_r;

  logic [CUBE_W:0]   rem_sh;
  logic [CUBE_W+1:0] diff;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  res;

  assign mag    = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign rem_sh = {rem_r[CUBE_W-1:0], quo_r[ACC_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

  // Control: start loads the operands, the count runs down one bit a cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CW'(ACC_W);
      rem_nxt  = '0;
      quo_nxt  = mag;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (!diff[CUBE_W+1]) begin
        rem_nxt = diff[CUBE_W:0];
        quo_nxt = {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[ACC_W-2:0], 1'b0};
      end
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctl.take) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (ctl.start) begin
      dsr_r <= divisor;
      neg_r <= dividend[ACC_W-1];
    end
  end

  // Sign restored on the magnitude quotient.
  assign res      = neg_r ? -quo_r : quo_r;
  assign quotient = res[SAMPLE_BITS-1:0];

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== rtl/vbad_back.sv =====
// Back part: plane accumulator memory, block sum update and averaging.
module vbad_back #(
  parameter int MAX_OUT_SIDE = vbad_pkg::MAX_OUT_SIDE_DEF,
  parameter int MAX_FACTOR   = vbad_pkg::MAX_FACTOR_DEF,
  parameter int SAMPLE_BITS  = vbad_pkg::SAMPLE_BITS_DEF,
  localparam int CUBE_W = $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR + 1),
  localparam int ADDR_W = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE * MAX_OUT_SIDE) : 1
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             q_empty,
  input  logic [SAMPLE_BITS+ADDR_W+vbad_pkg::FLAGS_W-1:0]  q_rdata,
  output logic                                             q_pop,
  input  logic [CUBE_W-1:0]                                cube,
  input  logic                                             out_ready,
  output logic                                             out_valid,
  output logic signed [SAMPLE_BITS-1:0]                    out_avg,
  output logic                                             out_last,
  output vbad_pkg::bk_status_t                             status
);

  localparam int DEPTH  = MAX_OUT_SIDE * MAX_OUT_SIDE;
  localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR) + 1;

  logic signed [ACC_W-1:0] plane_sums [DEPTH];

  vbad_pkg::bk_state_t  state_r, state_nxt;
  vbad_pkg::blk_flags_t q_flags, flags_r;
  logic [ADDR_W-1:0]       q_addr, addr_r;
  logic signed [SAMPLE_BITS-1:0] q_sample, sample_r;
  logic signed [ACC_W-1:0] rdata_r, sum;

  logic                    mem_we;
  logic                    out_free, out_load;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_last_r;
  logic signed [SAMPLE_BITS-1:0] out_avg_r;

  vbad_pkg::div_ctl_t       div_ctl;
  vbad_pkg::div_sts_t       div_sts;
  logic signed [SAMPLE_BITS-1:0] div_q;

  assign {q_sample, q_addr, q_flags} = q_rdata;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vbad_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = vbad_pkg::BK_ACC;
        end
      end
      vbad_pkg::BK_ACC: begin
        state_nxt = flags_r.last ? vbad_pkg::BK_DIV : vbad_pkg::BK_IDLE;
      end
      vbad_pkg::BK_DIV: begin
        if (div_sts.done && out_free) begin
          state_nxt = vbad_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = vbad_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.take  = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      vbad_pkg::BK_IDLE: begin
        q_pop = !q_empty;
      end
      vbad_pkg::BK_ACC: begin
        mem_we        = 1'b1;
        div_ctl.start = flags_r.last;
      end
      vbad_pkg::BK_DIV: begin
        out_load     = div_sts.done && out_free;
        div_ctl.take = div_sts.done && out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vbad_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request registers taken from the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= q_sample;
      addr_r   <= q_addr;
      flags_r  <= q_flags;
    end
  end

  // Accumulator memory: registered read at pop, write in the next cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata_r <= plane_sums[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      plane_sums[addr_r] <= sum;
    end
  end

  // The first voxel of a block replaces the stale sum.
  assign sum = flags_r.first ? ACC_W'(sample_r) : rdata_r + ACC_W'(sample_r);

  vbad_div #(
    .ACC_W       (ACC_W),
    .CUBE_W      (CUBE_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (sum),
    .divisor  (cube),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Volume end travels with the division.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r  <= div_q;
      out_last_r <= flags_r.vol_end;
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_last  = out_last_r;

  assign status.out_load  = out_load;
  assign status.div_start = div_ctl.start;
  assign status.div_busy  = div_sts.busy;

endmodule

// ===== rtl/volume_block_average_downsample.sv =====
// Top level of the volume block average downsampler.
//
//  Channel | Direction | Ports                         | Contents
//  --------+-----------+-------------------------------+-------------------------------
//  in      | slave     | in_tvalid in_tready in_tdata  | tdata: sample
//  out     | master    | out_tvalid out_tready         | tdata: average; tlast: volume_done
//          |           | out_tdata out_tlast           |
//  cfg     | write     | cfg_we cfg_index cfg_wdata    | 0: factor, 1: out_size
//
// An accepted voxel is written into the queue; the back part pops a request and reads its
// accumulator, then writes the updated sum, and pops no new request in between.
// After a block's last voxel the divider works out the average a quotient bit at a time,
// and it then goes to the output register; the front queues on while the queue has room.
// Reset is synchronous on rst_n; the accumulator memory needs no clearing pass.
// A stalled result waits in the output register and can hold the back part and the queue.
`include "assert_macros.svh"

module volume_block_average_downsample #(
  parameter int MAX_OUT_SIDE = vbad_pkg::MAX_OUT_SIDE_DEF,
  parameter int MAX_FACTOR   = vbad_pkg::MAX_FACTOR_DEF,
  parameter int SAMPLE_BITS  = vbad_pkg::SAMPLE_BITS_DEF,
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [TDATA_W-1:0]                   in_tdata,   // [SAMPLE_BITS-1:0] sample
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [TDATA_W-1:0]                   out_tdata,  // [SAMPLE_BITS-1:0] average
  output logic                                 out_tlast,
  // Configuration writes
  input  logic                                 cfg_we,
  input  logic [vbad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vbad_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CUBE_W  = $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR + 1);
  localparam int ADDR_W  = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE * MAX_OUT_SIDE) : 1;
  localparam int ITEM_W  = SAMPLE_BITS + ADDR_W + vbad_pkg::FLAGS_W;

  logic                   push, q_full, q_empty, q_pop;
  logic [ITEM_W-1:0]      f_item, q_rdata;
  logic [CUBE_W-1:0]      cube;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] avg_bits;
  vbad_pkg::bk_status_t   bk_status;

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  vbad_front #(
    .MAX_OUT_SIDE (MAX_OUT_SIDE),
    .MAX_FACTOR   (MAX_FACTOR),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .sample    (sample),
    .item      (f_item),
    .cube      (cube)
  );

  vbad_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  vbad_back #(
    .MAX_OUT_SIDE (MAX_OUT_SIDE),
    .MAX_FACTOR   (MAX_FACTOR),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .cube      (cube),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_avg   (avg),
    .out_last  (out_tlast),
    .status    (bk_status)
  );

  // Result packed into whole bytes, zero filled above the sample width.
  assign avg_bits  = avg;
  assign out_tdata = TDATA_W'(avg_bits);

  // The back part only pops requests that are present in the queue.
  `VBAD_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
  // A new result never overwrites one that is still waiting downstream.
  `VBAD_ASSERT_NOW(a_load_free, bk_status.out_load, !out_tvalid || out_tready)
  // The divider is never restarted in the middle of a division.
  `VBAD_ASSERT_NOW(a_div_start_idle, bk_status.div_start, !bk_status.div_busy)
  // A start sets the divider's busy flag.
  `VBAD_ASSERT_NEXT(a_div_busy_after_start, bk_status.div_start, bk_status.div_busy)

endmodule
